// File: design/tlpm_pkg.sv
// tlpm_pkg: constants, entry type and reset-pattern functions of the two-level page mapper
// no dependencies; used by two_level_page_mapper
`default_nettype none

package tlpm_pkg;

   localparam int FRAME_COUNT      = 8192;
   localparam int RESERVED_FRAMES  = 768;
   localparam int DIR_INDEX_BITS   = 10;
   localparam int TABLE_INDEX_BITS = 10;

   localparam int FRAME_BITS  = 13;
   localparam int DIR_SHIFT   = 22;
   localparam int PAGE_SHIFT  = 12;
   localparam int DIR_DEPTH   = 1 << DIR_INDEX_BITS;
   localparam int TABLE_DEPTH = 1 << TABLE_INDEX_BITS;
   localparam int PAGE_BITS   = DIR_INDEX_BITS + TABLE_INDEX_BITS;
   localparam int PAGE_DEPTH  = 1 << PAGE_BITS;

   localparam int WORD_SHIFT     = 6;
   localparam int WORD_BITS      = 1 << WORD_SHIFT;
   localparam int WORD_COUNT     = FRAME_COUNT / WORD_BITS;
   localparam int WORD_IDX_BITS  = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int FRAME_IDX_BITS = WORD_IDX_BITS + WORD_SHIFT;

   localparam int CLR_COUNT = (DIR_DEPTH > WORD_COUNT) ? DIR_DEPTH : WORD_COUNT;
   localparam int CNT_BITS0 = (DIR_INDEX_BITS > TABLE_INDEX_BITS) ?
                              DIR_INDEX_BITS : TABLE_INDEX_BITS;
   localparam int CNT_BITS  = (CNT_BITS0 > WORD_IDX_BITS) ? CNT_BITS0 : WORD_IDX_BITS;

   localparam logic [1:0] CMD_MAP_NEW   = 2'd0;
   localparam logic [1:0] CMD_MAP_GIVEN = 2'd1;
   localparam logic [1:0] CMD_REL_PAGE  = 2'd2;
   localparam logic [1:0] CMD_REL_FRAME = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_FRAME = 2'd1;
   localparam logic [1:0] ST_NO_TABLE = 2'd2;
   localparam logic [1:0] ST_UNUSED   = 2'd3;

   typedef logic [FRAME_BITS:0] entry_type;
   typedef logic [WORD_BITS-1:0] word_type;

   function automatic word_type reset_word(input logic [WORD_IDX_BITS-1:0] w);
      word_type r;
      r = '0;
      for (int b = 0; b < WORD_BITS; b++) begin
         r[b] = ((int'(w) * WORD_BITS + b) < RESERVED_FRAMES);
      end
      return r;
   endfunction

   function automatic logic [WORD_COUNT-1:0] full_reset();
      logic [WORD_COUNT-1:0] r;
      r = '0;
      for (int w = 0; w < WORD_COUNT; w++) begin
         r[w] = (((w + 1) * WORD_BITS) <= RESERVED_FRAMES);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: design/two_level_page_mapper.sv
// two_level_page_mapper: page directory, page tables and used-frame bitmap in block memories
// depends on tlpm_pkg
//
// Usage: one request transaction on req_* (cmd, vaddr, given_frame) gives exactly one
// response transaction on rsp_* (status, mapped_frame, table_frame, table_created,
// page_created). Both channels are valid/ready; one request is worked on at a time.
// Release frame reads its bitmap word and, for a frame in range, writes it back with the
// bit cleared. The other commands read the directory and page entries; a release page
// on a present table, a map with a given frame and a map that claims a page frame write
// the page memory and read the entries once more before responding. A map that creates
// a page table also zeroes that table's rows in the page memory, one row a cycle. A
// claim picks the first non-full bitmap word from a per-word full vector, reads it and
// sets its lowest clear bit. The next request is accepted in the cycle after a response
// is loaded. After reset the block runs a clearing pass over the directory and bitmap
// memories with req_ready low. A result is held in an output register until rsp_ready;
// the next request is accepted meanwhile and waits in its last state until the output
// register frees up.
`default_nettype none

module two_level_page_mapper (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_ready,
   input  wire  [1:0]                        req_cmd,
   input  wire  [31:0]                       req_vaddr,
   input  wire  [tlpm_pkg::FRAME_BITS-1:0]   req_given_frame,
   output logic                              rsp_valid,
   input  wire                               rsp_ready,
   output logic [1:0]                        rsp_status,
   output logic [tlpm_pkg::FRAME_BITS-1:0]   rsp_mapped_frame,
   output logic [tlpm_pkg::FRAME_BITS-1:0]   rsp_table_frame,
   output logic                              rsp_table_created,
   output logic                              rsp_page_created
);
   import tlpm_pkg::*;

   localparam logic [3:0] S_CLEAR    = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_SETTLE   = 4'd2;
   localparam logic [3:0] S_EVAL     = 4'd3;
   localparam logic [3:0] S_CLAIM_RD = 4'd4;
   localparam logic [3:0] S_CLAIM_WR = 4'd5;
   localparam logic [3:0] S_TCLEAR   = 4'd6;
   localparam logic [3:0] S_FREL_RD  = 4'd7;
   localparam logic [3:0] S_FREL_WR  = 4'd8;
   localparam logic [3:0] S_OUT      = 4'd9;

   word_type  bm_mem   [WORD_COUNT];
   entry_type dir_mem  [DIR_DEPTH];
   entry_type page_mem [PAGE_DEPTH];

   word_type  bm_q_ff;
   entry_type dir_q_ff;
   entry_type page_q_ff;

   logic [3:0]                  state_ff, state_in;
   logic [1:0]                  cmd_ff, cmd_in;
   logic [DIR_INDEX_BITS-1:0]   di_ff, di_in;
   logic [TABLE_INDEX_BITS-1:0] ti_ff, ti_in;
   logic [FRAME_BITS-1:0]       given_ff, given_in;
   logic                        tgt_tbl_ff, tgt_tbl_in;
   logic                        tc_ff, tc_in;
   logic                        pc_ff, pc_in;
   logic                        fin_ff, fin_in;
   logic                        relf_ff, relf_in;
   logic [1:0]                  status_ff, status_in;
   logic [CNT_BITS-1:0]         cnt_ff, cnt_in;
   logic [WORD_IDX_BITS-1:0]    word_ff, word_in;
   logic [WORD_COUNT-1:0]       full_ff, full_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [1:0]                  rsp_status_ff, rsp_status_in;
   logic [FRAME_BITS-1:0]       rsp_mapped_ff, rsp_mapped_in;
   logic [FRAME_BITS-1:0]       rsp_table_ff, rsp_table_in;
   logic                        rsp_tc_ff, rsp_tc_in;
   logic                        rsp_pc_ff, rsp_pc_in;

   logic [WORD_IDX_BITS-1:0]    bm_raddr;
   logic                        bm_we;
   logic [WORD_IDX_BITS-1:0]    bm_waddr;
   word_type                    bm_wdata;
   logic                        dir_we;
   logic [DIR_INDEX_BITS-1:0]   dir_waddr;
   entry_type                   dir_wdata;
   logic                        page_we;
   logic [PAGE_BITS-1:0]        page_waddr;
   entry_type                   page_wdata;

   logic [WORD_IDX_BITS-1:0]    free_word;
   logic                        any_free;
   logic [WORD_SHIFT-1:0]       zero_bit;
   word_type                    claim_word;
   logic [FRAME_IDX_BITS-1:0]   claim_idx;
   logic [FRAME_BITS-1:0]       claim_frame;
   logic                        given_in_range;
   logic [WORD_IDX_BITS-1:0]    given_word;
   logic [WORD_SHIFT-1:0]       given_bit;
   logic                        out_free;
   logic                        dir_p;
   logic                        page_p;

   assign req_ready         = (state_ff == S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_mapped_frame  = rsp_mapped_ff;
   assign rsp_table_frame   = rsp_table_ff;
   assign rsp_table_created = rsp_tc_ff;
   assign rsp_page_created  = rsp_pc_ff;

   assign dir_p    = dir_q_ff[FRAME_BITS];
   assign page_p   = page_q_ff[FRAME_BITS];
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign any_free = !(&full_ff);

   always_comb begin
      free_word = '0;
      for (int i = WORD_COUNT - 1; i >= 0; i--) begin
         if (!full_ff[i]) begin
            free_word = WORD_IDX_BITS'(i);
         end
      end
   end

   always_comb begin
      zero_bit = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (!bm_q_ff[b]) begin
            zero_bit = WORD_SHIFT'(b);
         end
      end
   end

   always_comb begin
      claim_word           = bm_q_ff;
      claim_word[zero_bit] = 1'b1;
   end

   assign claim_idx      = {word_ff, zero_bit};
   assign claim_frame    = FRAME_BITS'(claim_idx);
   assign given_in_range = ({19'd0, given_ff} < 32'(FRAME_COUNT));
   assign given_word     = WORD_IDX_BITS'(given_ff >> WORD_SHIFT);
   assign given_bit      = given_ff[WORD_SHIFT-1:0];

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      di_in         = di_ff;
      ti_in         = ti_ff;
      given_in      = given_ff;
      tgt_tbl_in    = tgt_tbl_ff;
      tc_in         = tc_ff;
      pc_in         = pc_ff;
      fin_in        = fin_ff;
      relf_in       = relf_ff;
      status_in     = status_ff;
      cnt_in        = cnt_ff;
      word_in       = word_ff;
      full_in       = full_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_mapped_in = rsp_mapped_ff;
      rsp_table_in  = rsp_table_ff;
      rsp_tc_in     = rsp_tc_ff;
      rsp_pc_in     = rsp_pc_ff;
      bm_raddr      = free_word;
      bm_we         = 1'b0;
      bm_waddr      = word_ff;
      bm_wdata      = claim_word;
      dir_we        = 1'b0;
      dir_waddr     = di_ff;
      dir_wdata     = {1'b1, claim_frame};
      page_we       = 1'b0;
      page_waddr    = {di_ff, ti_ff};
      page_wdata    = {1'b1, claim_frame};

      case (state_ff)
         S_CLEAR: begin
            if (int'(cnt_ff) < DIR_DEPTH) begin
               dir_we    = 1'b1;
               dir_waddr = cnt_ff[DIR_INDEX_BITS-1:0];
               dir_wdata = '0;
            end
            if (int'(cnt_ff) < WORD_COUNT) begin
               bm_we    = 1'b1;
               bm_waddr = cnt_ff[WORD_IDX_BITS-1:0];
               bm_wdata = reset_word(cnt_ff[WORD_IDX_BITS-1:0]);
            end
            cnt_in = cnt_ff + 1'b1;
            if (int'(cnt_ff) == CLR_COUNT - 1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd_in    = req_cmd;
               di_in     = DIR_INDEX_BITS'(req_vaddr >> DIR_SHIFT);
               ti_in     = TABLE_INDEX_BITS'(req_vaddr >> PAGE_SHIFT);
               given_in  = req_given_frame;
               tc_in     = 1'b0;
               pc_in     = 1'b0;
               fin_in    = 1'b0;
               relf_in   = (req_cmd == CMD_REL_FRAME);
               status_in = ST_OK;
               state_in  = (req_cmd == CMD_REL_FRAME) ? S_FREL_RD : S_SETTLE;
            end
         end
         S_SETTLE: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (fin_ff) begin
               state_in = S_OUT;
            end else if (cmd_ff == CMD_REL_PAGE) begin
               if (!dir_p) begin
                  status_in = ST_NO_TABLE;
                  state_in  = S_OUT;
               end else begin
                  page_we    = 1'b1;
                  page_wdata = '0;
                  fin_in     = 1'b1;
                  state_in   = S_SETTLE;
               end
            end else if (!dir_p) begin
               if (any_free) begin
                  tgt_tbl_in = 1'b1;
                  state_in   = S_CLAIM_RD;
               end else begin
                  status_in = ST_NO_FRAME;
                  state_in  = S_OUT;
               end
            end else if (!page_p) begin
               if (cmd_ff == CMD_MAP_GIVEN) begin
                  page_we    = 1'b1;
                  page_wdata = {1'b1, given_ff};
                  pc_in      = 1'b1;
                  fin_in     = 1'b1;
                  state_in   = S_SETTLE;
               end else if (any_free) begin
                  tgt_tbl_in = 1'b0;
                  state_in   = S_CLAIM_RD;
               end else begin
                  status_in = ST_NO_FRAME;
                  state_in  = S_OUT;
               end
            end else begin
               state_in = S_OUT;
            end
         end
         S_CLAIM_RD: begin
            bm_raddr = free_word;
            word_in  = free_word;
            state_in = S_CLAIM_WR;
         end
         S_CLAIM_WR: begin
            bm_we            = 1'b1;
            full_in[word_ff] = &claim_word;
            if (tgt_tbl_ff) begin
               dir_we   = 1'b1;
               tc_in    = 1'b1;
               cnt_in   = '0;
               state_in = S_TCLEAR;
            end else begin
               page_we  = 1'b1;
               pc_in    = 1'b1;
               fin_in   = 1'b1;
               state_in = S_SETTLE;
            end
         end
         S_TCLEAR: begin
            page_we    = 1'b1;
            page_waddr = {di_ff, cnt_ff[TABLE_INDEX_BITS-1:0]};
            page_wdata = '0;
            cnt_in     = cnt_ff + 1'b1;
            if (int'(cnt_ff) == TABLE_DEPTH - 1) begin
               state_in = S_SETTLE;
            end
         end
         S_FREL_RD: begin
            bm_raddr = given_word;
            word_in  = given_word;
            state_in = given_in_range ? S_FREL_WR : S_OUT;
         end
         S_FREL_WR: begin
            bm_we               = 1'b1;
            bm_wdata            = bm_q_ff;
            bm_wdata[given_bit] = 1'b0;
            full_in[word_ff]    = 1'b0;
            state_in            = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_mapped_in = (dir_p && page_p && !relf_ff) ? page_q_ff[FRAME_BITS-1:0] : '0;
               rsp_table_in  = (dir_p && !relf_ff) ? dir_q_ff[FRAME_BITS-1:0] : '0;
               rsp_tc_in     = tc_ff;
               rsp_pc_in     = pc_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         full_ff      <= full_reset();
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         full_ff      <= full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      di_ff         <= di_in;
      ti_ff         <= ti_in;
      given_ff      <= given_in;
      tgt_tbl_ff    <= tgt_tbl_in;
      tc_ff         <= tc_in;
      pc_ff         <= pc_in;
      fin_ff        <= fin_in;
      relf_ff       <= relf_in;
      status_ff     <= status_in;
      word_ff       <= word_in;
      rsp_status_ff <= rsp_status_in;
      rsp_mapped_ff <= rsp_mapped_in;
      rsp_table_ff  <= rsp_table_in;
      rsp_tc_ff     <= rsp_tc_in;
      rsp_pc_ff     <= rsp_pc_in;
   end

   always_ff @(posedge clock) begin
      if (bm_we) begin
         bm_mem[bm_waddr] <= bm_wdata;
      end
      bm_q_ff <= bm_mem[bm_raddr];
   end

   always_ff @(posedge clock) begin
      if (dir_we) begin
         dir_mem[dir_waddr] <= dir_wdata;
      end
      dir_q_ff <= dir_mem[di_ff];
   end

   always_ff @(posedge clock) begin
      if (page_we) begin
         page_mem[page_waddr] <= page_wdata;
      end
      page_q_ff <= page_mem[{di_ff, ti_ff}];
   end

   // lowest free frame must come from a word with a clear bit
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLAIM_WR) |-> !(&bm_q_ff))
      else $error("claim from a full bitmap word");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !req_ready)
      else $error("request taken during clearing pass");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_page_created) |-> (rsp_status == ST_OK))
      else $error("page created with error status");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status != ST_UNUSED))
      else $error("undefined status code");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_NO_TABLE)) |-> !rsp_table_created && !rsp_page_created)
      else $error("release page on absent table changed state");

endmodule

`default_nettype wire
